/* rtl/core/slb_pkg.sv */
// slb_pkg: shared types, codes and the set-1 scancode translation functions
// for the scancode line buffer. No dependencies.
`default_nettype none

package slb_pkg;

   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic RESULT_CHAR = 1'b0;
   localparam logic RESULT_DONE = 1'b1;

   localparam int COUNT_W = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] SC_SHIFT_PRESS   = 8'h36;
   localparam logic [7:0] SC_RELEASE_BIT   = 8'h80;
   localparam logic [7:0] SC_SHIFT_RELEASE = SC_SHIFT_PRESS | SC_RELEASE_BIT;

   typedef enum logic {
      OP_APPEND,
      OP_READ
   } op_type;

   // payload is the character for an append and the length for a read
   typedef struct packed {
      op_type     op;
      logic [7:0] payload;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SERVE,
      ST_EMIT,
      ST_DONE
   } state_type;

   function automatic logic code_accepted(input logic [7:0] code);
      return (code >= 8'h02 && code <= 8'h29) || (code >= 8'h2b && code <= 8'h35) ||
             code == 8'h39 || code == 8'h4a || code == 8'h4c || code == 8'h4e;
   endfunction

   function automatic logic [7:0] plain_char(input logic [7:0] code);
      logic [7:0] ch;
      unique case (code)
         8'h01: ch = 8'h1b;
         8'h02: ch = 8'h31;
         8'h03: ch = 8'h32;
         8'h04: ch = 8'h33;
         8'h05: ch = 8'h34;
         8'h06: ch = 8'h35;
         8'h07: ch = 8'h36;
         8'h08: ch = 8'h37;
         8'h09: ch = 8'h38;
         8'h0a: ch = 8'h39;
         8'h0b: ch = 8'h30;
         8'h0c: ch = 8'h2d;
         8'h0d: ch = 8'h3d;
         8'h0e: ch = 8'h08;
         8'h0f: ch = 8'h09;
         8'h10: ch = 8'h71;
         8'h11: ch = 8'h77;
         8'h12: ch = 8'h65;
         8'h13: ch = 8'h72;
         8'h14: ch = 8'h74;
         8'h15: ch = 8'h79;
         8'h16: ch = 8'h75;
         8'h17: ch = 8'h69;
         8'h18: ch = 8'h6f;
         8'h19: ch = 8'h70;
         8'h1a: ch = 8'h5b;
         8'h1b: ch = 8'h5d;
         8'h1c: ch = 8'h0a;
         8'h1e: ch = 8'h61;
         8'h1f: ch = 8'h73;
         8'h20: ch = 8'h64;
         8'h21: ch = 8'h66;
         8'h22: ch = 8'h67;
         8'h23: ch = 8'h68;
         8'h24: ch = 8'h6a;
         8'h25: ch = 8'h6b;
         8'h26: ch = 8'h6c;
         8'h27: ch = 8'h3b;
         8'h28: ch = 8'h27;
         8'h29: ch = 8'h60;
         8'h2b: ch = 8'h5c;
         8'h2c: ch = 8'h7a;
         8'h2d: ch = 8'h78;
         8'h2e: ch = 8'h63;
         8'h2f: ch = 8'h76;
         8'h30: ch = 8'h62;
         8'h31: ch = 8'h6e;
         8'h32: ch = 8'h6d;
         8'h33: ch = 8'h2c;
         8'h34: ch = 8'h2e;
         8'h35: ch = 8'h2f;
         8'h39: ch = 8'h20;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] shift_char(input logic [7:0] code);
      logic [7:0] base;
      logic [7:0] ch;
      base = plain_char(code);
      unique case (code)
         8'h02: ch = 8'h21;
         8'h03: ch = 8'h40;
         8'h04: ch = 8'h23;
         8'h05: ch = 8'h24;
         8'h06: ch = 8'h25;
         8'h07: ch = 8'h5e;
         8'h08: ch = 8'h26;
         8'h09: ch = 8'h2a;
         8'h0a: ch = 8'h28;
         8'h0b: ch = 8'h29;
         8'h0c: ch = 8'h5f;
         8'h0d: ch = 8'h2b;
         8'h1a: ch = 8'h7b;
         8'h1b: ch = 8'h7d;
         8'h27: ch = 8'h3a;
         8'h28: ch = 8'h22;
         8'h29: ch = 8'h7e;
         8'h2b: ch = 8'h7c;
         8'h33: ch = 8'h3c;
         8'h34: ch = 8'h3e;
         8'h35: ch = 8'h3f;
         // letters go upper case, the rest match the plain map
         default: ch = (base >= 8'h61 && base <= 8'h7a) ? (base & 8'hdf) : base;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/slb_if.sv */
// slb_req_if and slb_rsp_if: valid/ready channels of the line buffer.
// Depends on nothing.
`default_nettype none

interface slb_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] scan_code;
   logic [7:0] read_len;

   modport source (output valid, kind, scan_code, read_len, input ready);
   modport sink   (input valid, kind, scan_code, read_len, output ready);
endinterface

interface slb_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [5:0] delivered_count;
   logic       last;

   modport source (output valid, result_kind, data_byte, delivered_count, last, input ready);
   modport sink   (input valid, result_kind, data_byte, delivered_count, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/slb_front.sv */
// slb_front: takes request beats, tracks shift, translates scancodes and
// queues append/read commands. Depends on slb_pkg and slb_req_if.
`default_nettype none

module slb_front import slb_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   slb_req_if.sink    req,
   output push_type   push,
   input  wire logic  push_ready
);

   logic shift_ff;
   logic shift_in;
   logic beat;

   assign req.ready = push_ready;
   assign beat      = req.valid && push_ready;

   always_comb begin
      shift_in          = shift_ff;
      push.valid        = 1'b0;
      push.cmd.op       = OP_APPEND;
      push.cmd.payload  = shift_ff ? shift_char(req.scan_code) : plain_char(req.scan_code);
      if (req.kind == KIND_READ) begin
         push.valid       = req.valid;
         push.cmd.op      = OP_READ;
         push.cmd.payload = req.read_len;
      end else if (req.scan_code == SC_SHIFT_PRESS) begin
         shift_in = beat ? 1'b1 : shift_ff;
      end else if (req.scan_code == SC_SHIFT_RELEASE) begin
         shift_in = beat ? 1'b0 : shift_ff;
      end else begin
         push.valid = req.valid && code_accepted(req.scan_code);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/slb_queue.sv */
// slb_queue: two-entry command queue between front and back end.
// Depends on slb_pkg.
`default_nettype none

module slb_queue import slb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          push_ready,
   output logic          pop_valid,
   output cmd_type       pop_cmd,
   input  wire logic     pop_ready
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/slb_back.sv */
// slb_back: line store, fill tracking, waiting read and result output register.
// Depends on slb_pkg and slb_rsp_if.
`default_nettype none

module slb_back import slb_pkg::*; #(
   parameter int LINE_CHARS = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    pop_valid,
   input  wire cmd_type pop_cmd,
   output logic         pop_ready,
   slb_rsp_if.source    rsp
);

   localparam int PTR_W  = $clog2(LINE_CHARS);
   localparam int FILL_W = $clog2(LINE_CHARS + 1);

   logic [7:0]        mem [LINE_CHARS];
   logic [7:0]        rd_data_ff;

   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic              pend_ff, pend_in;
   logic [7:0]        pend_len_ff, pend_len_in;
   logic [7:0]        len_left_ff, len_left_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_kind_ff, out_kind_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   logic              out_last_ff, out_last_in;

   logic              mem_we, mem_re, out_free;
   logic [FILL_W:0]   wr_sum;
   logic [PTR_W-1:0]  wr_addr, rp_next;
   logic [FILL_W-1:0] fill_plus;

   assign wr_sum    = (FILL_W + 1)'(rp_ff) + (FILL_W + 1)'(fill_ff);
   assign wr_addr   = (wr_sum >= (FILL_W + 1)'(LINE_CHARS)) ?
                      PTR_W'(wr_sum - (FILL_W + 1)'(LINE_CHARS)) : PTR_W'(wr_sum);
   assign rp_next   = (rp_ff == PTR_W'(LINE_CHARS - 1)) ? '0 : rp_ff + 1'b1;
   assign fill_plus = fill_ff + 1'b1;
   assign out_free  = !out_valid_ff || rsp.ready;

   assign rsp.valid           = out_valid_ff;
   assign rsp.result_kind     = out_kind_ff;
   assign rsp.data_byte       = out_data_ff;
   assign rsp.delivered_count = out_cnt_ff;
   assign rsp.last            = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rp_in        = rp_ff;
      pend_in      = pend_ff;
      pend_len_in  = pend_len_ff;
      len_left_in  = len_left_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_kind_in  = out_kind_ff;
      out_data_in  = out_data_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      pop_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               unique case (pop_cmd.op)
                  OP_APPEND: begin
                     mem_we = 1'b1;
                     if (fill_plus == FILL_W'(LINE_CHARS)) begin
                        // store full: contents dropped, waiting read stays
                        fill_in = '0;
                        rp_in   = '0;
                     end else begin
                        fill_in = fill_plus;
                        if (pend_ff) begin
                           pend_in     = 1'b0;
                           pend_len_in = '0;
                           len_left_in = pend_len_ff;
                           cnt_in      = '0;
                           state_in    = ST_SERVE;
                        end
                     end
                  end
                  OP_READ: begin
                     if (fill_ff == '0) begin
                        pend_in     = 1'b1;
                        pend_len_in = pop_cmd.payload;
                     end else begin
                        len_left_in = pop_cmd.payload;
                        cnt_in      = '0;
                        state_in    = ST_SERVE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SERVE: begin
            if (len_left_ff != '0 && fill_ff != '0) begin
               mem_re      = 1'b1;
               rp_in       = (fill_ff == FILL_W'(1)) ? '0 : rp_next;
               fill_in     = fill_ff - 1'b1;
               len_left_in = len_left_ff - 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               state_in    = ST_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RESULT_CHAR;
               out_data_in  = rd_data_ff;
               out_cnt_in   = '0;
               out_last_in  = 1'b0;
               state_in     = ST_SERVE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = RESULT_DONE;
               out_data_in  = '0;
               out_cnt_in   = cnt_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= pop_cmd.payload;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      len_left_ff <= len_left_in;
      cnt_ff      <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rp_ff        <= '0;
         pend_ff      <= 1'b0;
         pend_len_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rp_ff        <= rp_in;
         pend_ff      <= pend_in;
         pend_len_ff  <= pend_len_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/scancode_line_buffer_top.sv */
// scancode_line_buffer_top: set-1 scancode to ASCII line buffer.
// Depends on slb_pkg, slb_if, slb_front, slb_queue and slb_back.
//
//   channel   dir   beat contents
//   req_bus   in    kind, scan_code, read_len
//   rsp_bus   out   result_kind, data_byte, delivered_count, last
//
// a request beat is taken while the two-entry command queue has room
// the back end takes one queued command per cycle while idle
// a read goes: accept, then per byte a store read and an output load,
// then the end check and the completion beat
// a stalled rsp_bus holds the output register; the queue absorbs two commands, then req_bus stalls
// synchronous reset clears shift, fill, read pointer, the waiting read, queue and output valid
`default_nettype none

module scancode_line_buffer_top import slb_pkg::*; #(
   parameter int LINE_CHARS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   slb_req_if.sink   req_bus,
   slb_rsp_if.source rsp_bus
);

   push_type push;
   logic     push_ready;
   logic     pop_valid;
   cmd_type  pop_cmd;
   logic     pop_ready;

   slb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push       (push),
      .push_ready (push_ready)
   );

   slb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   slb_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

/* rtl/core/slb_checker.sv */
// slb_checker: port-level assertions on the line buffer result channel,
// bound to scancode_line_buffer_top. Depends on slb_pkg.
`default_nettype none

module slb_checker import slb_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_result_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [5:0] rsp_delivered_count,
   input wire logic       rsp_last
);

   // nothing offered right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // stalled beat stays up
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // character beats carry no count and never end a run
   a_char_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_CHAR |->
         rsp_delivered_count == '0 && !rsp_last)
      else $error("character beat with count or last");

   // completion beats end the run with a zero data byte
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == RESULT_DONE |-> rsp_last && rsp_data_byte == '0)
      else $error("completion beat malformed");

endmodule

bind scancode_line_buffer_top slb_checker u_slb_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_result_kind     (rsp_bus.result_kind),
   .rsp_data_byte       (rsp_bus.data_byte),
   .rsp_delivered_count (rsp_bus.delivered_count),
   .rsp_last            (rsp_bus.last)
);

`default_nettype wire

/* verif/tb_scancode_line_buffer_top.sv */
`timescale 1ns / 1ps
// tb_scancode_line_buffer_top: self-checking bench for the scancode line buffer,
// directed script then random keystroke and read beats against a local line model.
// Depends on slb_pkg, slb_if and scancode_line_buffer_top.

module tb_scancode_line_buffer_top;
   import slb_pkg::*;

   localparam int LINE_CHARS   = 32;
   localparam int RANDOM_ITEMS = 270;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_PCT     = 24;

   localparam logic [7:0] KEY_ROW_A_LO  = 8'h02;
   localparam logic [7:0] KEY_ROW_A_HI  = 8'h29;
   localparam logic [7:0] KEY_ROW_B_LO  = 8'h2b;
   localparam logic [7:0] KEY_ROW_B_HI  = 8'h35;
   localparam logic [7:0] KEY_SPACE     = 8'h39;
   localparam logic [7:0] KEY_PAD_MINUS = 8'h4a;
   localparam logic [7:0] KEY_PAD_FIVE  = 8'h4c;
   localparam logic [7:0] KEY_PAD_PLUS  = 8'h4e;
   localparam logic [7:0] MAP_END       = 8'h3a;

   localparam logic [0:57][7:0] PLAIN_MAP = {
      8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
      8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   localparam logic [0:57][7:0] SHIFT_MAP = {
      8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
      8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
      8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h00,
      8'h00, 8'h20
   };

   typedef struct packed {
      logic       kind;
      logic [7:0] scan_code;
      logic [7:0] read_len;
   } key_beat_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] data_byte;
      logic [5:0] delivered_count;
      logic       last;
   } line_beat_type;

   typedef struct packed {
      logic            kind;
      logic [7:0]      value;
      logic            typed;
      logic [2:0]      n_chars;
      logic [0:3][7:0] chars;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;
   logic calm = 1'b0;
   logic hold_trigger = 1'b0;
   logic hold_used = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int rsp_beats = 0;
   int burst_left = 0;

   // line model state
   logic model_shift = 1'b0;
   logic [7:0] model_store [0:LINE_CHARS-1];
   int model_fill = 0;
   int model_rptr = 0;
   logic model_pending = 1'b0;
   int model_pending_len = 0;

   line_beat_type owed_line_beats[$];
   line_beat_type fresh_line_beats[$];
   script_row_type script [0:24];

   slb_req_if req_bus ();
   slb_rsp_if rsp_bus ();

   assign rsp_bus.ready = sink_ready;

   scancode_line_buffer_top #(.LINE_CHARS(LINE_CHARS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at rsp beat %0d: %s got %0h want %0h", rsp_beats, what, got, want);
      mismatches++;
   endtask

   function automatic void serve_line_read(input int want);
      int n;
      int i;
      line_beat_type lb;
      n = (want < model_fill) ? want : model_fill;
      for (i = 0; i < n; i++) begin
         lb.result_kind = RESULT_CHAR;
         lb.data_byte = model_store[(model_rptr + i) % LINE_CHARS];
         lb.delivered_count = 6'd0;
         lb.last = 1'b0;
         fresh_line_beats.push_back(lb);
      end
      lb.result_kind = RESULT_DONE;
      lb.data_byte = 8'h00;
      lb.delivered_count = 6'(n);
      lb.last = 1'b1;
      fresh_line_beats.push_back(lb);
      if (want >= model_fill) begin
         model_fill = 0;
         model_rptr = 0;
      end else begin
         model_fill = model_fill - want;
         model_rptr = (model_rptr + want) % LINE_CHARS;
      end
   endfunction

   // returns 0 when the beat leaves the block untouched
   function automatic bit apply_key_beat(input key_beat_type b);
      logic [7:0] c;
      logic [7:0] ch;
      int want;
      fresh_line_beats.delete();
      c = b.scan_code;
      if (b.kind == KIND_READ) begin
         if (model_fill == 0) begin
            model_pending = 1'b1;
            model_pending_len = int'(b.read_len);
         end else begin
            serve_line_read(int'(b.read_len));
         end
         return 1'b1;
      end
      if (c == SC_SHIFT_PRESS) begin
         model_shift = 1'b1;
         return 1'b1;
      end
      if (c == SC_SHIFT_RELEASE) begin
         model_shift = 1'b0;
         return 1'b1;
      end
      if (!((c >= KEY_ROW_A_LO && c <= KEY_ROW_A_HI) ||
            (c >= KEY_ROW_B_LO && c <= KEY_ROW_B_HI) ||
            c == KEY_SPACE || c == KEY_PAD_MINUS || c == KEY_PAD_FIVE ||
            c == KEY_PAD_PLUS)) begin
         return 1'b0;
      end
      ch = 8'h00;
      if (c < MAP_END) begin
         ch = model_shift ? SHIFT_MAP[c[5:0]] : PLAIN_MAP[c[5:0]];
      end
      model_store[(model_rptr + model_fill) % LINE_CHARS] = ch;
      model_fill++;
      // store full discards the line
      if (model_fill >= LINE_CHARS) begin
         model_fill = 0;
         model_rptr = 0;
      end
      if (model_pending && model_fill != 0) begin
         want = model_pending_len;
         model_pending = 1'b0;
         model_pending_len = 0;
         serve_line_read(want);
      end
      return 1'b1;
   endfunction

   function automatic logic [7:0] random_typing_key();
      int r;
      r = $urandom_range(54);
      if (r < 40) begin
         return KEY_ROW_A_LO + 8'(r);
      end
      if (r < 51) begin
         return KEY_ROW_B_LO + 8'(r - 40);
      end
      case (r)
         51: begin
            return KEY_SPACE;
         end
         52: begin
            return KEY_PAD_MINUS;
         end
         53: begin
            return KEY_PAD_FIVE;
         end
         default: begin
            return KEY_PAD_PLUS;
         end
      endcase
   endfunction

   function automatic key_beat_type random_key_beat();
      key_beat_type b;
      int pick;
      b.kind = KIND_SCAN;
      b.scan_code = random_typing_key();
      b.read_len = 8'($urandom);
      pick = $urandom_range(99);
      if (burst_left > 0) begin
         burst_left--;
      end else if (pick < 6) begin
         // long typing run, enough to wrap the store
         burst_left = $urandom_range(40, 31);
      end else if (pick < 12) begin
         b.scan_code = ($urandom_range(1) == 1) ? SC_SHIFT_PRESS : SC_SHIFT_RELEASE;
      end else if (pick < 20) begin
         b.scan_code = 8'($urandom);
      end else if (pick < 44) begin
         b.kind = KIND_READ;
         b.scan_code = 8'($urandom);
         pick = $urandom_range(99);
         if (pick < 15) begin
            b.read_len = 8'd0;
         end else if (pick < 25) begin
            b.read_len = 8'hff;
         end else if (pick >= 40) begin
            b.read_len = 8'($urandom_range(8, 1));
         end
      end
      return b;
   endfunction

   function automatic script_row_type row(input logic kind, input logic [7:0] value,
                                          input logic typed, input logic [2:0] n_chars,
                                          input logic [0:3][7:0] chars);
      script_row_type r;
      r.kind = kind;
      r.value = value;
      r.typed = typed;
      r.n_chars = n_chars;
      r.chars = chars;
      return r;
   endfunction

   task automatic send_key_beat(input key_beat_type b);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= b.kind;
      req_bus.scan_code <= b.scan_code;
      req_bus.read_len <= b.read_len;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
   endtask

   // receiver, with one long hold-off so the command queue backs up
   always @(posedge clock) begin
      if (hold_trigger && !hold_used) begin
         hold_used = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      line_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_line_beats.size() == 0) begin
            report_mismatch("unexpected beat, data", int'(rsp_bus.data_byte), 0);
         end else begin
            want = owed_line_beats.pop_front();
            if (rsp_bus.result_kind !== want.result_kind) begin
               report_mismatch("result_kind", int'(rsp_bus.result_kind),
                               int'(want.result_kind));
            end
            if (rsp_bus.data_byte !== want.data_byte) begin
               report_mismatch("data_byte", int'(rsp_bus.data_byte), int'(want.data_byte));
            end
            if (rsp_bus.delivered_count !== want.delivered_count) begin
               report_mismatch("delivered_count", int'(rsp_bus.delivered_count),
                               int'(want.delivered_count));
            end
            if (rsp_bus.last !== want.last) begin
               report_mismatch("last", int'(rsp_bus.last), int'(want.last));
            end
         end
         rsp_beats++;
      end
   end

   initial begin
      key_beat_type b;
      line_beat_type lb;
      int k;
      int useful;

      req_bus.valid = 1'b0;
      req_bus.kind = KIND_SCAN;
      req_bus.scan_code = 8'h00;
      req_bus.read_len = 8'h00;

      script = '{
         row(KIND_READ, 8'd3, 1'b0, 3'd0, '0),           // read on empty store waits
         row(KIND_READ, 8'd5, 1'b0, 3'd0, '0),           // replaces the waiting read
         row(KIND_SCAN, 8'h02, 1'b1, 3'd1, {8'h31, 8'h00, 8'h00, 8'h00}),
         row(KIND_SCAN, SC_SHIFT_PRESS, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'h02, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'h10, 1'b0, 3'd0, '0),
         row(KIND_SCAN, SC_SHIFT_RELEASE, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'h10, 1'b0, 3'd0, '0),
         row(KIND_READ, 8'd0, 1'b1, 3'd0, '0),           // zero-length read
         row(KIND_READ, 8'd2, 1'b1, 3'd2, {8'h21, 8'h51, 8'h00, 8'h00}),
         row(KIND_SCAN, 8'h1d, 1'b0, 3'd0, '0),          // zero table entry
         row(KIND_SCAN, KEY_PAD_MINUS, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_PAD_FIVE, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_PAD_PLUS, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'h01, 1'b0, 3'd0, '0),          // ignored codes
         row(KIND_SCAN, 8'h2a, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'h00, 1'b0, 3'd0, '0),
         row(KIND_SCAN, 8'hff, 1'b0, 3'd0, '0),
         row(KIND_SCAN, MAP_END, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_ROW_A_HI, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_ROW_B_LO, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_ROW_B_HI, 1'b0, 3'd0, '0),
         row(KIND_SCAN, KEY_SPACE, 1'b0, 3'd0, '0),
         row(KIND_READ, 8'hff, 1'b0, 3'd0, '0),          // drains the whole line
         row(KIND_READ, 8'd1, 1'b0, 3'd0, '0)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         b.kind = script[i].kind;
         b.scan_code = (script[i].kind == KIND_SCAN) ? script[i].value : 8'($urandom);
         b.read_len = (script[i].kind == KIND_READ) ? script[i].value : 8'($urandom);
         send_key_beat(b);
         void'(apply_key_beat(b));
         if (script[i].typed) begin
            for (k = 0; k < script[i].n_chars; k++) begin
               lb.result_kind = RESULT_CHAR;
               lb.data_byte = script[i].chars[k];
               lb.delivered_count = 6'd0;
               lb.last = 1'b0;
               owed_line_beats.push_back(lb);
            end
            lb.result_kind = RESULT_DONE;
            lb.data_byte = 8'h00;
            lb.delivered_count = 6'(script[i].n_chars);
            lb.last = 1'b1;
            owed_line_beats.push_back(lb);
         end else begin
            while (fresh_line_beats.size() != 0) begin
               owed_line_beats.push_back(fresh_line_beats.pop_front());
            end
         end
      end

      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         calm = (useful >= 150 && useful < 210);
         b = random_key_beat();
         if (!hold_trigger && useful >= 60 &&
             ((b.kind == KIND_READ && model_fill > 2) || useful >= 200)) begin
            hold_trigger = 1'b1;
         end
         send_key_beat(b);
         if (apply_key_beat(b)) begin
            useful++;
         end
         while (fresh_line_beats.size() != 0) begin
            owed_line_beats.push_back(fresh_line_beats.pop_front());
         end
      end
      calm = 1'b0;
      req_bus.valid <= 1'b0;

      while (owed_line_beats.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
